// ===== rtl/kway_merge_min_select_macros.svh =====
// ----------------------------------------------------------------------------
// kway_merge_min_select_macros
// assertion macros shared by the merge block
// ----------------------------------------------------------------------------
`ifndef KWAY_MERGE_MIN_SELECT_MACROS_SVH
`define KWAY_MERGE_MIN_SELECT_MACROS_SVH

// same-cycle implication, checked out of reset
`define KMMS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define KMMS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/kmms_pkg.sv =====
// ----------------------------------------------------------------------------
// kmms_pkg
// types, constants and helpers for the k-way merge minimum selector
// ----------------------------------------------------------------------------
package kmms_pkg;

    // number of list slots held by the block
    localparam int MAX_LISTS = 8;
    localparam int LANES     = (MAX_LISTS < 8) ? MAX_LISTS : 8;
    // leaves of the selection tree, fixed by the 3-bit list index
    localparam int TREE_LEAVES = 8;

    typedef logic signed [31:0]  value_t;
    typedef logic [2:0]          idx_t;
    typedef logic [3:0]          count_t;
    typedef logic [LANES-1:0]    lane_mask_t;

    // answer codes; code 3 is ignored
    typedef enum logic [1:0] {
        ACT_VALUE     = 2'd0,
        ACT_EXHAUSTED = 2'd1,
        ACT_RESTART   = 2'd2
    } action_t;

    localparam count_t LISTS_RESET = 4'd8;

    typedef struct packed {
        logic [1:0] action;
        idx_t       list_index;
        value_t     value;
    } item_t;

    typedef struct packed {
        value_t out_value;
        idx_t   out_list;
        logic   done_res;
        logic   bad_item;
    } result_t;

    // mask of lists taking part, zero counts as one, saturated to the slots
    function automatic lane_mask_t lane_mask(input count_t n_cfg);
        int         n;
        lane_mask_t m;
        n = int'(n_cfg);
        if (n == 0)
        begin
            n = 1;
        end
        if (n > LANES)
        begin
            n = LANES;
        end
        for (int i = 0; i < LANES; i++)
        begin
            m[i] = (i < n);
        end
        return m;
    endfunction

endpackage

// ===== rtl/kmms_if.sv =====
// ----------------------------------------------------------------------------
// kmms interfaces
// valid/ready channels for answers, results and the configuration write
// ----------------------------------------------------------------------------
interface kmms_in_if;
    logic                 valid;
    logic                 ready;
    logic [1:0]           action;
    kmms_pkg::idx_t       list_index;
    kmms_pkg::value_t     value;

    modport source (output valid, action, list_index, value, input ready);
    modport sink   (input valid, action, list_index, value, output ready);
endinterface

interface kmms_out_if;
    logic                 valid;
    logic                 ready;
    kmms_pkg::value_t     out_value;
    kmms_pkg::idx_t       out_list;
    logic                 done_res;
    logic                 bad_item;

    modport source (output valid, out_value, out_list, done_res, bad_item, input ready);
    modport sink   (input valid, out_value, out_list, done_res, bad_item, output ready);
endinterface

interface kmms_cfg_if;
    logic                 valid;
    logic                 ready;
    kmms_pkg::count_t     lists_in_use;

    modport source (output valid, lists_in_use, input ready);
    modport sink   (input valid, lists_in_use, output ready);
endinterface

// ===== rtl/kmms_in_stage.sv =====
// ----------------------------------------------------------------------------
// kmms_in_stage
// input register: holds one answer until the update stage takes it
// ----------------------------------------------------------------------------
module kmms_in_stage (
    input  logic            clk,
    input  logic            rst_n,
    kmms_in_if.sink         item,
    input  logic            take,
    output logic            held_valid,
    output kmms_pkg::item_t held
);
    import kmms_pkg::*;

    logic  valid_reg;
    item_t item_reg;

    // room when empty or when the held answer moves on this cycle
    assign item.ready = !valid_reg || take;

    // valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (item.ready)
        begin
            valid_reg <= item.valid;
        end
    end

    // payload, loaded on each transfer
    always_ff @(posedge clk)
    begin
        if (item.valid && item.ready)
        begin
            item_reg <= '{action: item.action, list_index: item.list_index,
                          value: item.value};
        end
    end

    assign held_valid = valid_reg;
    assign held       = item_reg;

endmodule

// ===== rtl/kmms_min_tree.sv =====
// ----------------------------------------------------------------------------
// kmms_min_tree
// three-level comparator tree picking the smallest valid head, lower index
// winning ties
// ----------------------------------------------------------------------------
module kmms_min_tree (
    input  kmms_pkg::value_t     vals [kmms_pkg::LANES],
    input  kmms_pkg::lane_mask_t valid,
    output logic                 found,
    output kmms_pkg::idx_t       best_idx,
    output kmms_pkg::value_t     best_val
);
    import kmms_pkg::*;

    logic   lv_v [4][TREE_LEAVES];
    value_t lv_d [4][TREE_LEAVES];
    idx_t   lv_x [4][TREE_LEAVES];

    always_comb
    begin
        // leaves, unused slots padded as empty
        for (int i = 0; i < TREE_LEAVES; i++)
        begin
            lv_v[0][i] = (i < LANES) ? valid[i] : 1'b0;
            lv_d[0][i] = (i < LANES) ? vals[i] : '0;
            lv_x[0][i] = idx_t'(i);
        end
        for (int l = 1; l < 4; l++)
        begin
            for (int i = 0; i < TREE_LEAVES; i++)
            begin
                lv_v[l][i] = 1'b0;
                lv_d[l][i] = '0;
                lv_x[l][i] = '0;
            end
        end
        // pairwise reduction; right side wins only when strictly smaller
        for (int l = 1; l < 4; l++)
        begin
            for (int i = 0; i < (TREE_LEAVES >> l); i++)
            begin
                if (lv_v[l-1][2*i+1] &&
                    (!lv_v[l-1][2*i] || (lv_d[l-1][2*i+1] < lv_d[l-1][2*i])))
                begin
                    lv_v[l][i] = 1'b1;
                    lv_d[l][i] = lv_d[l-1][2*i+1];
                    lv_x[l][i] = lv_x[l-1][2*i+1];
                end
                else
                begin
                    lv_v[l][i] = lv_v[l-1][2*i];
                    lv_d[l][i] = lv_d[l-1][2*i];
                    lv_x[l][i] = lv_x[l-1][2*i];
                end
            end
        end
    end

    assign found    = lv_v[3][0];
    assign best_idx = lv_x[3][0];
    assign best_val = lv_d[3][0];

endmodule

// ===== rtl/kway_merge_min_select.sv =====
// ----------------------------------------------------------------------------
// kway_merge_min_select
// k-way merge of sorted lists: one head slot per list, pops the smallest
// head once every awaited list has answered
// ----------------------------------------------------------------------------
//  channel   direction  carries
//  item      in         action, list_index, value
//  result    out        out_value, out_list, done_res, bad_item
//  cfg       in         lists_in_use (applies at next restart)
//
//  one answer per cycle sustained unless the result stalls; input register
//  then the combinational head update and comparator tree into the result register
//  reset leaves no heads valid and every list in use awaited
//  a stalled result holds the update stage; the input register still takes
//  one more answer behind it
// ----------------------------------------------------------------------------
`include "kway_merge_min_select_macros.svh"

module kway_merge_min_select (
    input  logic     clk,
    input  logic     rst_n,
    kmms_in_if.sink  item,
    kmms_out_if.source result,
    kmms_cfg_if.sink cfg
);
    import kmms_pkg::*;

    // stage and state registers
    logic       held_valid;
    item_t      held;
    logic       take;
    count_t     lists_reg;
    lane_mask_t valid_reg, valid_next;
    lane_mask_t awaited_reg, awaited_next;
    value_t     head_values_reg [LANES];
    logic       out_valid_reg;
    result_t    out_reg;

    // update logic signals
    logic       is_val, is_exh, is_rst;
    logic       idx_ok;
    lane_mask_t idx_bit, aw_after, valid_after, best_bit;
    value_t     vals_after [LANES];
    logic       found;
    idx_t       best_idx;
    value_t     best_val;
    logic       emit;
    result_t    res;

    kmms_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item),
        .take       (take),
        .held_valid (held_valid),
        .held       (held)
    );

    // update stage moves when the result register is free or draining
    assign take = held_valid && (!out_valid_reg || result.ready);

    // configuration write, always accepted
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lists_reg <= LISTS_RESET;
        end
        else if (cfg.valid)
        begin
            lists_reg <= cfg.lists_in_use;
        end
    end

    // decode the held answer
    assign is_val  = (held.action == ACT_VALUE);
    assign is_exh  = (held.action == ACT_EXHAUSTED);
    assign is_rst  = (held.action == ACT_RESTART);
    assign idx_ok  = (int'(held.list_index) < LANES) && awaited_reg[held.list_index];
    assign idx_bit = lane_mask_t'(1) << held.list_index;

    // state as it stands once this answer is applied
    assign aw_after    = awaited_reg & ~idx_bit;
    assign valid_after = is_val ? (valid_reg | idx_bit) : (valid_reg & ~idx_bit);

    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            vals_after[i] = (is_val && (held.list_index == idx_t'(i))) ? held.value
                                                                        : head_values_reg[i];
        end
    end

    kmms_min_tree u_tree (
        .vals     (vals_after),
        .valid    (valid_after),
        .found    (found),
        .best_idx (best_idx),
        .best_val (best_val)
    );

    assign best_bit = lane_mask_t'(1) << best_idx;

    // next state and result
    always_comb
    begin
        valid_next   = valid_reg;
        awaited_next = awaited_reg;
        emit         = 1'b0;
        res          = '0;
        if (is_rst)
        begin
            valid_next   = '0;
            awaited_next = lane_mask(lists_reg);
        end
        else if (is_val || is_exh)
        begin
            if (!idx_ok)
            begin
                emit         = 1'b1;
                res.bad_item = 1'b1;
            end
            else if (aw_after != '0)
            begin
                valid_next   = valid_after;
                awaited_next = aw_after;
            end
            else if (!found)
            begin
                valid_next   = valid_after;
                awaited_next = '0;
                emit         = 1'b1;
                res.done_res = 1'b1;
            end
            else
            begin
                valid_next    = valid_after & ~best_bit;
                awaited_next  = best_bit;
                emit          = 1'b1;
                res.out_value = best_val;
                res.out_list  = best_idx;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= '0;
            awaited_reg <= lane_mask(LISTS_RESET);
        end
        else if (take)
        begin
            valid_reg   <= valid_next;
            awaited_reg <= awaited_next;
        end
    end

    // head slots, written on an accepted value answer
    always_ff @(posedge clk)
    begin
        if (take && is_val && idx_ok)
        begin
            head_values_reg[held.list_index] <= held.value;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            out_valid_reg <= emit;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && emit)
        begin
            out_reg <= res;
        end
    end

    assign result.valid     = out_valid_reg;
    assign result.out_value = out_reg.out_value;
    assign result.out_list  = out_reg.out_list;
    assign result.done_res  = out_reg.done_res;
    assign result.bad_item  = out_reg.bad_item;

    // checks
    `KMMS_ASSERT_NOW(a_no_valid_awaited, 1'b1, (valid_reg & awaited_reg) == '0, "awaited list holds a valid head")
    `KMMS_ASSERT_NEXT(a_pop_awaits_one, take && emit && !res.done_res && !res.bad_item, $onehot(awaited_reg), "pop must await exactly one list")
    `KMMS_ASSERT_NEXT(a_done_empty, take && emit && res.done_res, (awaited_reg == '0) && (valid_reg == '0), "done left state behind")

endmodule

// ===== test/tb_kway_merge_min_select.sv =====
// ----------------------------------------------------------------------------
// tb_kway_merge_min_select
// drives host answers into the k-way merge selector and checks every result
// transfer against a cycle-free merge predictor kept alongside the block;
// a directed table covers the reset state, ties, extremes and rejected
// answers, then random merge sessions run over a range of list counts
// ----------------------------------------------------------------------------
module tb_kway_merge_min_select;

    import kmms_pkg::*;

    // action code the block ignores
    localparam logic [1:0] ACT_IGNORED = 2'd3;

    localparam value_t VAL_MIN = 32'sh8000_0000;
    localparam value_t VAL_MAX = 32'sh7FFF_FFFF;

    localparam result_t RES_NONE = '0;
    localparam result_t RES_BAD  = '{out_value: '0, out_list: '0, done_res: 1'b0,
                                     bad_item: 1'b1};
    localparam result_t RES_DONE = '{out_value: '0, out_list: '0, done_res: 1'b1,
                                     bad_item: 1'b0};

    // where a directed row takes its expectation from
    typedef enum bit {
        BY_PREDICTOR = 1'b0,
        BY_TABLE     = 1'b1
    } check_src_t;

    typedef struct packed {
        logic [1:0] act;
        idx_t       list;
        value_t     val;
        check_src_t src;
        logic       emits;
        result_t    res;
    } answer_row_t;

    logic clk = 1'b0;
    logic rst_n;

    kmms_in_if  item_ch ();
    kmms_out_if res_ch ();
    kmms_cfg_if cfg_ch ();

    kway_merge_min_select dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (res_ch),
        .cfg    (cfg_ch)
    );

    // merge predictor state
    value_t     head_vals [LANES];
    lane_mask_t head_ok;
    lane_mask_t waiting;
    count_t     list_count_cfg;

    result_t merge_outputs_q [$];

    int answer_gap_max   = 8;
    int result_stall_max = 8;
    int n_answers        = 0;
    int n_cfg            = 0;
    int n_values         = 0;
    int n_done           = 0;
    int n_bad            = 0;
    int n_err            = 0;

    answer_row_t dir_tbl [24];

    // clock
    always #6 clk = ~clk;

    function automatic result_t emitted(input value_t v, input idx_t l);
        result_t r;
        r           = '0;
        r.out_value = v;
        r.out_list  = l;
        return r;
    endfunction

    // clear the heads and await every list in use
    task automatic restart_heads();
        int n;
        n = int'(list_count_cfg);
        if (n == 0)
        begin
            n = 1;
        end
        if (n > LANES)
        begin
            n = LANES;
        end
        for (int i = 0; i < LANES; i++)
        begin
            head_vals[i] = '0;
        end
        head_ok = '0;
        waiting = lane_mask_t'((1 << n) - 1);
    endtask

    // one host answer: update the heads, pop the smallest once nothing is awaited
    task automatic merge_predict(input logic [1:0] act, input idx_t lst, input value_t v,
                                 output logic emits, output result_t r);
        lane_mask_t sel;
        int         best;
        bit         found;
        emits = 1'b0;
        r     = '0;
        if (act == ACT_RESTART)
        begin
            restart_heads();
            return;
        end
        if (act == ACT_IGNORED)
        begin
            return;
        end
        sel = lane_mask_t'(1) << lst;
        emits = 1'b1;
        // answer for a list that is not awaited
        if ((waiting & sel) == '0)
        begin
            r = RES_BAD;
            return;
        end
        waiting = waiting & ~sel;
        if (act == ACT_VALUE)
        begin
            head_vals[lst] = v;
            head_ok        = head_ok | sel;
        end
        else
        begin
            head_ok = head_ok & ~sel;
        end
        if (waiting != '0)
        begin
            emits = 1'b0;
            return;
        end
        // smallest valid head, lower list wins a tie
        found = 1'b0;
        best  = 0;
        for (int i = 0; i < LANES; i++)
        begin
            if (head_ok[i] && (!found || head_vals[i] < head_vals[best]))
            begin
                found = 1'b1;
                best  = i;
            end
        end
        if (!found)
        begin
            r = RES_DONE;
            return;
        end
        head_ok[best] = 1'b0;
        waiting       = lane_mask_t'(1) << best;
        r             = emitted(head_vals[best], idx_t'(best));
    endtask

    // offer one answer, wait for its transfer, then record what it should cause
    task automatic offer_answer(input logic [1:0] act, input idx_t lst, input value_t v,
                                input check_src_t src, input logic typed_emits,
                                input result_t typed_res);
        int      gap;
        logic    emits;
        result_t pred;
        gap = $urandom_range(0, answer_gap_max);
        if (gap > 0)
        begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_ch.valid      <= 1'b1;
        item_ch.action     <= act;
        item_ch.list_index <= lst;
        item_ch.value      <= v;
        do @(posedge clk); while (!item_ch.ready);
        merge_predict(act, lst, v, emits, pred);
        if (src == BY_TABLE)
        begin
            emits = typed_emits;
            pred  = typed_res;
        end
        if (emits)
        begin
            merge_outputs_q.push_back(pred);
        end
        if (act != ACT_IGNORED)
        begin
            n_answers++;
        end
    endtask

    // register write, only once every result is out and the pipeline is empty
    task automatic set_list_count(input count_t n);
        item_ch.valid <= 1'b0;
        while (merge_outputs_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
        cfg_ch.valid        <= 1'b1;
        cfg_ch.lists_in_use <= n;
        do @(posedge clk); while (!cfg_ch.ready);
        cfg_ch.valid   <= 1'b0;
        list_count_cfg = n;
        n_cfg++;
    endtask

    // one merge of ascending lists with some noise mixed in
    task automatic merge_session(input bit small_vals);
        int         left [LANES];
        longint     tail [LANES];
        int         pick;
        int         step;
        logic [1:0] act;
        value_t     v;
        for (int i = 0; i < LANES; i++)
        begin
            left[i] = $urandom_range(0, 6);
            if (small_vals)
            begin
                tail[i] = longint'(int'($urandom_range(0, 20))) - 10;
            end
            else if ($urandom_range(0, 7) == 0)
            begin
                tail[i] = longint'(VAL_MIN);
            end
            else
            begin
                tail[i] = longint'(int'($urandom));
            end
        end
        while (waiting != '0)
        begin
            if ($urandom_range(0, 11) == 0)
            begin
                // noise: anything at all, restarts included
                act  = 2'($urandom_range(0, 3));
                pick = $urandom_range(0, 7);
                v    = value_t'($urandom);
            end
            else
            begin
                do pick = $urandom_range(0, LANES - 1); while (!waiting[pick]);
                if (left[pick] == 0)
                begin
                    act = ACT_EXHAUSTED;
                    v   = value_t'($urandom);
                end
                else
                begin
                    act  = ACT_VALUE;
                    v    = value_t'(tail[pick]);
                    step = small_vals ? $urandom_range(0, 2) : $urandom_range(0, 32'h00FF_FFFF);
                    tail[pick] += step;
                    left[pick] = (tail[pick] > longint'(VAL_MAX)) ? 0 : left[pick] - 1;
                end
            end
            offer_answer(act, idx_t'(pick), v, BY_PREDICTOR, 1'b0, RES_NONE);
        end
        // late answers once the merge is done
        repeat ($urandom_range(0, 2))
        begin
            offer_answer(2'($urandom_range(0, 1)), idx_t'($urandom_range(0, 7)),
                         value_t'($urandom), BY_PREDICTOR, 1'b0, RES_NONE);
        end
    endtask

    task automatic report_field(input string name, input longint want, input longint got);
        $display("%0t: %s expected %0d got %0d", $time, name, want, got);
        n_err++;
    endtask

    // result side: random stalls, each transfer checked against the oldest expectation
    initial
    begin
        int      stall;
        result_t want;
        result_t got;
        stall = 0;
        res_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n === 1'b1 && res_ch.valid === 1'b1 && res_ch.ready === 1'b1)
            begin
                got = '{res_ch.out_value, res_ch.out_list, res_ch.done_res, res_ch.bad_item};
                if (got.bad_item)
                begin
                    n_bad++;
                end
                else if (got.done_res)
                begin
                    n_done++;
                end
                else
                begin
                    n_values++;
                end
                if (merge_outputs_q.size() == 0)
                begin
                    $display("%0t: result transfer with nothing expected, value %0d list %0d",
                             $time, got.out_value, got.out_list);
                    n_err++;
                end
                else
                begin
                    want = merge_outputs_q.pop_front();
                    if (got.out_value !== want.out_value)
                    begin
                        report_field("out_value", want.out_value, got.out_value);
                    end
                    if (got.out_list !== want.out_list)
                    begin
                        report_field("out_list", want.out_list, got.out_list);
                    end
                    if (got.done_res !== want.done_res)
                    begin
                        report_field("done_res", want.done_res, got.done_res);
                    end
                    if (got.bad_item !== want.bad_item)
                    begin
                        report_field("bad_item", want.bad_item, got.bad_item);
                    end
                end
                stall = $urandom_range(0, result_stall_max);
                res_ch.ready <= (stall == 0);
            end
            else if (res_ch.ready !== 1'b1)
            begin
                if (stall > 0)
                begin
                    stall--;
                end
                if (stall == 0)
                begin
                    res_ch.ready <= 1'b1;
                end
            end
        end
    end

    // stimulus
    initial
    begin
        int     plan [7];
        int     random_goal;
        int     spins;
        count_t n;
        plan = '{1, 0, 15, 8, 9, 2, 5};
        dir_tbl = '{
            // reset state: all eight lists awaited, ignored code, extremes stored
            '{ACT_IGNORED,   3'd0, 32'sd0,          BY_TABLE, 1'b0, RES_NONE},
            '{ACT_VALUE,     3'd0, VAL_MAX,         BY_TABLE, 1'b0, RES_NONE},
            '{ACT_VALUE,     3'd1, VAL_MIN,         BY_TABLE, 1'b0, RES_NONE},
            '{ACT_EXHAUSTED, 3'd2, 32'sd0,          BY_TABLE, 1'b0, RES_NONE},
            // second answer for the same list
            '{ACT_VALUE,     3'd2, 32'sd123,        BY_TABLE, 1'b1, RES_BAD},
            '{ACT_VALUE,     3'd3, -32'sd1,         BY_TABLE, 1'b0, RES_NONE},
            '{ACT_VALUE,     3'd4, 32'sd0,          BY_TABLE, 1'b0, RES_NONE},
            '{ACT_VALUE,     3'd5, 32'sd0,          BY_TABLE, 1'b0, RES_NONE},
            '{ACT_EXHAUSTED, 3'd6, 32'sd0,          BY_TABLE, 1'b0, RES_NONE},
            // ties at the minimum go to the lower list
            '{ACT_VALUE,     3'd7, VAL_MIN,         BY_TABLE, 1'b1, emitted(VAL_MIN, 3'd1)},
            '{ACT_VALUE,     3'd1, VAL_MIN,         BY_TABLE, 1'b1, emitted(VAL_MIN, 3'd1)},
            '{ACT_EXHAUSTED, 3'd1, 32'sd0,          BY_TABLE, 1'b1, emitted(VAL_MIN, 3'd7)},
            '{ACT_EXHAUSTED, 3'd7, 32'sd0,          BY_TABLE, 1'b1, emitted(-32'sd1, 3'd3)},
            '{ACT_VALUE,     3'd0, 32'sd55,         BY_TABLE, 1'b1, RES_BAD},
            '{ACT_EXHAUSTED, 3'd3, 32'sd0,          BY_TABLE, 1'b1, emitted(32'sd0, 3'd4)},
            '{ACT_EXHAUSTED, 3'd4, 32'sd0,          BY_TABLE, 1'b1, emitted(32'sd0, 3'd5)},
            '{ACT_EXHAUSTED, 3'd5, 32'sd0,          BY_TABLE, 1'b1, emitted(VAL_MAX, 3'd0)},
            '{ACT_EXHAUSTED, 3'd0, 32'sd0,          BY_TABLE, 1'b1, RES_DONE},
            // answers after done
            '{ACT_VALUE,     3'd0, 32'sd7,          BY_TABLE, 1'b1, RES_BAD},
            '{ACT_EXHAUSTED, 3'd7, 32'sd0,          BY_TABLE, 1'b1, RES_BAD},
            // restart ignores its index and value
            '{ACT_RESTART,   3'd5, 32'shDEAD_BEEF,  BY_TABLE, 1'b0, RES_NONE},
            '{ACT_VALUE,     3'd6, 32'sh2A5A_5A5A,  BY_PREDICTOR, 1'b0, RES_NONE},
            '{ACT_IGNORED,   3'd7, -32'sd1,         BY_PREDICTOR, 1'b0, RES_NONE},
            '{ACT_RESTART,   3'd0, 32'sd0,          BY_PREDICTOR, 1'b0, RES_NONE}
        };

        rst_n               <= 1'b0;
        item_ch.valid       <= 1'b0;
        item_ch.action      <= '0;
        item_ch.list_index  <= '0;
        item_ch.value       <= '0;
        cfg_ch.valid        <= 1'b0;
        cfg_ch.lists_in_use <= '0;
        list_count_cfg = LISTS_RESET;
        restart_heads();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        foreach (dir_tbl[i])
        begin
            offer_answer(dir_tbl[i].act, dir_tbl[i].list, dir_tbl[i].val, dir_tbl[i].src,
                         dir_tbl[i].emits, dir_tbl[i].res);
        end

        // random merge sessions, one list count per phase
        random_goal = n_answers + 1250;
        for (int phase = 0; n_answers < random_goal; phase++)
        begin
            n = (phase < 7) ? count_t'(plan[phase]) : count_t'($urandom_range(0, 15));
            set_list_count(n);
            answer_gap_max   = ($urandom_range(0, 3) == 0) ? 0 : 8;
            result_stall_max = ($urandom_range(0, 3) == 0) ? 0 : 8;
            offer_answer(ACT_RESTART, idx_t'($urandom_range(0, 7)), value_t'($urandom),
                         BY_PREDICTOR, 1'b0, RES_NONE);
            for (int s = $urandom_range(1, 4); s > 0; s--)
            begin
                merge_session(1'($urandom_range(0, 1)));
                if (s > 1)
                begin
                    offer_answer(ACT_RESTART, '0, '0, BY_PREDICTOR, 1'b0, RES_NONE);
                end
            end
        end

        // drain, then a quiet tail to catch stray results
        item_ch.valid <= 1'b0;
        spins = 0;
        while (merge_outputs_q.size() != 0 && spins < 5000)
        begin
            @(posedge clk);
            spins++;
        end
        if (merge_outputs_q.size() != 0)
        begin
            $display("%0t: %0d expected results never arrived", $time,
                     merge_outputs_q.size());
            n_err++;
        end
        repeat (8) @(posedge clk);

        $display("%0d host answers over %0d list-count writes (0, 1, 8 and 15 included)",
                 n_answers, n_cfg);
        $display("%0d merged values, %0d done marks, %0d rejected answers seen, %0d errors",
                 n_values, n_done, n_bad, n_err);
        if (n_err == 0)
        begin
            $display("tb_kway_merge_min_select: done, clean");
        end
        else
        begin
            $display("tb_kway_merge_min_select: done, errors");
        end
        $finish;
    end

    // run limit
    initial
    begin
        #8000000;
        $display("%0t: run limit reached", $time);
        $display("tb_kway_merge_min_select: done, errors");
        $finish;
    end

endmodule
